// ===== rtl/core/zcd_pkg.sv =====
// Shared types and constants of the zero-crossing edge detector.
// No dependencies; every other file of the block but zcd_ram imports this package.
package zcd_pkg;

    // Default geometry and sample format
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int ROW_BITS      = 10;
    localparam int COL_BITS      = 10;
    localparam int GEOM_BITS     = 11;
    localparam int STR_BITS      = 17;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 17;

    // Geometry limits and reset values
    localparam int GEOM_MIN    = 3;
    localparam int HEIGHT_MAX  = 1024;
    localparam int WIDTH_RST   = 640;
    localparam int HEIGHT_RST  = 480;

    localparam logic [STR_BITS-1:0] STRENGTH_MAX = 17'h1FFFF;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_WIDTH     = 2'd0,
        CFG_HEIGHT    = 2'd1,
        CFG_THRESHOLD = 2'd2
    } zcd_cfg_t;

    // Position and class of the pixel an item describes
    typedef struct packed {
        logic                emit;      // item yields a result
        logic                interior;  // not on a border
        logic                last;      // last result of the frame
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
    } zcd_pos_t;

endpackage

// ===== rtl/core/zero_crossing_edge_detector_unit.sv =====
// Top level of the Laplacian zero-crossing edge detector.
// Depends on zcd_pkg, zcd_line_buf (with zcd_ram) and zcd_cross.
//
// Usage:
//   s_ channel: signed second-derivative samples in raster order, one item
//   per pixel. m_ channel: one result item per input item from row 1 on,
//   describing the pixel one row above the input (row 0 inputs give none,
//   the last row of a frame is never described). Border pixels report
//   strength 0 and edge_res 0; frame_last marks the final result of a frame.
//   cfg_ channel: writes image_width (0), image_height (1) and
//   edge_threshold (2); width and height are clamped to their legal range.
//   Write configuration only while the block is idle.
// Timing:
//   Throughput is one item per clock while m_ready is high. Each item reads
//   the line buffer RAMs (middle row at two columns via a second RAM copy,
//   older row at one), then is computed into the output register.
// Reset:
//   Row/column counters clear, registers return to 640 x 480, threshold 0.
//   Line buffers are not cleared; the first row only fills them.
// Stall:
//   While m_ready is low the output register holds its item, one more
//   item waits in the read stage, and s_ready drops until space frees up.
module zero_crossing_edge_detector_unit
    import zcd_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    // input samples
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SAMPLE_BITS-1:0]   s_sample,
    // results
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [ROW_BITS-1:0]      m_row_index,
    output logic [COL_BITS-1:0]      m_col_index,
    output logic [STR_BITS-1:0]      m_strength,
    output logic                     m_edge_res,
    output logic                     m_frame_last
);

    localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

    // ---------------- configuration ----------------
    logic [GEOM_BITS-1:0] width_reg;
    logic [GEOM_BITS-1:0] height_reg;
    logic [STR_BITS-1:0]  thresh_reg;
    logic [GEOM_BITS-1:0] wr_geom;
    logic [GEOM_BITS-1:0] width_clamp;
    logic [GEOM_BITS-1:0] height_clamp;

    assign cfg_ready = 1'b1;
    assign wr_geom   = cfg_wdata[GEOM_BITS-1:0];

    always_comb begin
        if (wr_geom < GEOM_BITS'(GEOM_MIN)) begin
            width_clamp = GEOM_BITS'(GEOM_MIN);
        end else if (32'(wr_geom) > MAX_WIDTH) begin
            width_clamp = GEOM_BITS'(MAX_WIDTH);
        end else begin
            width_clamp = wr_geom;
        end
        if (wr_geom < GEOM_BITS'(GEOM_MIN)) begin
            height_clamp = GEOM_BITS'(GEOM_MIN);
        end else if (wr_geom > GEOM_BITS'(HEIGHT_MAX)) begin
            height_clamp = GEOM_BITS'(HEIGHT_MAX);
        end else begin
            height_clamp = wr_geom;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= GEOM_BITS'(W_RST);
            height_reg <= GEOM_BITS'(HEIGHT_RST);
            thresh_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (zcd_cfg_t'(cfg_addr))
                CFG_WIDTH:     width_reg  <= width_clamp;
                CFG_HEIGHT:    height_reg <= height_clamp;
                CFG_THRESHOLD: thresh_reg <= cfg_wdata[STR_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------- raster position ----------------
    logic [ROW_BITS-1:0]  row_reg;
    logic [COL_BITS-1:0]  col_reg;
    logic [ROW_BITS-1:0]  row_next;
    logic [COL_BITS-1:0]  col_next;
    logic [COL_BITS:0]    col_p1;
    logic [COL_BITS:0]    col_p2;
    logic [ROW_BITS:0]    row_p1;
    zcd_pos_t             pos_next;
    logic                 accept;

    assign accept = s_valid && s_ready;
    assign col_p1 = {1'b0, col_reg} + (COL_BITS+1)'(1);
    assign col_p2 = {1'b0, col_reg} + (COL_BITS+1)'(2);
    assign row_p1 = {1'b0, row_reg} + (ROW_BITS+1)'(1);

    always_comb begin
        if (col_p1 >= width_reg) begin
            col_next = '0;
            row_next = (row_p1 >= height_reg) ? '0 : ROW_BITS'(row_p1);
        end else begin
            col_next = COL_BITS'(col_p1);
            row_next = row_reg;
        end
        // classify the pixel one row above the incoming sample
        pos_next.emit     = (row_reg != '0);
        pos_next.interior = (row_reg >= ROW_BITS'(2)) && (row_p1 <= height_reg)
                            && (col_reg != '0) && (col_p2 <= width_reg);
        pos_next.last     = (row_p1 == height_reg) && (col_p1 == width_reg);
        pos_next.row      = row_reg - ROW_BITS'(1);
        pos_next.col      = col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ---------------- read stage ----------------
    // RAM data for the item arrives here; the write-back of the item's
    // column happens while it sits in this stage. With width >= 3 the next
    // item never reads a column written in the same cycle, so no bypass.
    logic                   s1_valid_reg;
    zcd_pos_t               s1_pos_reg;
    logic [SAMPLE_BITS-1:0] s1_down_reg;
    logic [SAMPLE_BITS-1:0] left_reg;
    logic                   s1_adv;
    logic                   out_free;
    logic                   load;
    logic [SAMPLE_BITS-1:0] mid_c;
    logic [SAMPLE_BITS-1:0] mid_c1;
    logic [SAMPLE_BITS-1:0] old_c;

    assign out_free = !m_valid || m_ready;
    assign s1_adv   = s1_valid_reg && (!s1_pos_reg.emit || out_free);
    assign load     = s1_adv && s1_pos_reg.emit;
    assign s_ready  = !s1_valid_reg || s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            left_reg     <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                left_reg <= mid_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pos_reg  <= pos_next;
            s1_down_reg <= s_sample;
        end
    end

    zcd_line_buf #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line_buf (
        .clk     (aclk),
        .rd_en   (accept),
        .rd_col  (col_reg),
        .wr_en   (s1_valid_reg),
        .wr_col  (s1_pos_reg.col),
        .wr_down (s1_down_reg),
        .mid_c   (mid_c),
        .mid_c1  (mid_c1),
        .old_c   (old_c)
    );

    // ---------------- compute and output ----------------
    zcd_cross #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cross (
        .clk          (aclk),
        .rst_n        (aresetn),
        .load         (load),
        .pos          (s1_pos_reg),
        .centre       (mid_c),
        .left         (left_reg),
        .up           (old_c),
        .right        (mid_c1),
        .down         (s1_down_reg),
        .threshold    (thresh_reg),
        .out_ready    (m_ready),
        .out_valid    (m_valid),
        .out_row      (m_row_index),
        .out_col      (m_col_index),
        .out_strength (m_strength),
        .out_edge     (m_edge_res),
        .out_last     (m_frame_last)
    );

endmodule

// ===== rtl/core/zcd_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module zcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/zcd_line_buf.sv =====
// Two line buffers of the detector, built from zcd_ram instances.
// Depends on zcd_pkg and zcd_ram.
module zcd_line_buf
    import zcd_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [COL_BITS-1:0]    rd_col,
    input  logic                   wr_en,
    input  logic [COL_BITS-1:0]    wr_col,
    input  logic [SAMPLE_BITS-1:0] wr_down,
    output logic [SAMPLE_BITS-1:0] mid_c,
    output logic [SAMPLE_BITS-1:0] mid_c1,
    output logic [SAMPLE_BITS-1:0] old_c
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [COL_BITS:0] rd_col_p1;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     rd_addr_p1;
    logic [AW-1:0]     wr_addr;
    logic              wr_ok;

    assign rd_col_p1  = {1'b0, rd_col} + (COL_BITS+1)'(1);
    assign rd_addr    = AW'(rd_col);
    assign rd_addr_p1 = AW'(rd_col_p1);
    assign wr_addr    = AW'(wr_col);
    // columns past the buffer depth are never stored
    assign wr_ok      = wr_en && (32'(wr_col) < MAX_WIDTH);

    // middle row, copy read at the pixel's column
    zcd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_mid_a (
        .clk     (clk),
        .wr_en   (wr_ok),
        .wr_addr (wr_addr),
        .wr_data (wr_down),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (mid_c)
    );

    // middle row, copy read at the right neighbor
    zcd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_mid_b (
        .clk     (clk),
        .wr_en   (wr_ok),
        .wr_addr (wr_addr),
        .wr_data (wr_down),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_p1),
        .rd_data (mid_c1)
    );

    // older row takes the middle value it replaces
    zcd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_old (
        .clk     (clk),
        .wr_en   (wr_ok),
        .wr_addr (wr_addr),
        .wr_data (mid_c),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (old_c)
    );

endmodule

// ===== rtl/core/zcd_cross.sv =====
// Crossing strength, threshold compare and the result output register.
// Depends on zcd_pkg.
module zcd_cross
    import zcd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  zcd_pos_t               pos,
    input  logic [SAMPLE_BITS-1:0] centre,
    input  logic [SAMPLE_BITS-1:0] left,
    input  logic [SAMPLE_BITS-1:0] up,
    input  logic [SAMPLE_BITS-1:0] right,
    input  logic [SAMPLE_BITS-1:0] down,
    input  logic [STR_BITS-1:0]    threshold,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [ROW_BITS-1:0]    out_row,
    output logic [COL_BITS-1:0]    out_col,
    output logic [STR_BITS-1:0]    out_strength,
    output logic                   out_edge,
    output logic                   out_last
);

    localparam int SB = SAMPLE_BITS;
    localparam int SW = SB + 2;
    localparam int EW = (SW > STR_BITS) ? SW : STR_BITS;

    function automatic logic [SB:0] pair_mag(logic [SB-1:0] a, logic [SB-1:0] b);
        logic [SB-1:0] ma;
        logic [SB-1:0] mb;
        ma = a[SB-1] ? (~a + SB'(1)) : a;
        mb = b[SB-1] ? (~b + SB'(1)) : b;
        if ((a != '0) && (b != '0) && (a[SB-1] != b[SB-1])) begin
            return {1'b0, ma} + {1'b0, mb};
        end
        return '0;
    endfunction

    logic [SB-1:0]       h_a;
    logic [SB-1:0]       v_a;
    logic [SW-1:0]       sum;
    logic [EW-1:0]       sum_ext;
    logic [STR_BITS-1:0] strength;

    logic                valid_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [COL_BITS-1:0] col_reg;
    logic [STR_BITS-1:0] strength_reg;
    logic                edge_reg;
    logic                last_reg;

    always_comb begin
        // a zero pixel borrows its left or upper neighbor
        h_a = (centre == '0) ? left : centre;
        v_a = (centre == '0) ? up : centre;
        sum = {1'b0, pair_mag(h_a, right)} + {1'b0, pair_mag(v_a, down)};
        sum_ext = EW'(sum);
        if (!pos.interior) begin
            strength = '0;
        end else if (sum_ext > EW'(STRENGTH_MAX)) begin
            strength = STRENGTH_MAX;
        end else begin
            strength = STR_BITS'(sum_ext);
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            row_reg      <= pos.row;
            col_reg      <= pos.col;
            strength_reg <= strength;
            edge_reg     <= (strength > threshold);
            last_reg     <= pos.last;
        end
    end

    assign out_valid    = valid_reg;
    assign out_row      = row_reg;
    assign out_col      = col_reg;
    assign out_strength = strength_reg;
    assign out_edge     = edge_reg;
    assign out_last     = last_reg;

endmodule

// ===== rtl/core/zcd_checker.sv =====
// Port-level checks of the edge detector, bound to the top level.
// Depends on zcd_pkg and zero_crossing_edge_detector_unit.
module zcd_checker
    import zcd_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [ROW_BITS-1:0] m_row_index,
    input logic [COL_BITS-1:0] m_col_index,
    input logic [STR_BITS-1:0] m_strength,
    input logic                m_edge_res,
    input logic                m_frame_last
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_index)
            && $stable(m_col_index) && $stable(m_strength)
            && $stable(m_edge_res) && $stable(m_frame_last))
        else $error("result item changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an edge needs a strength above the threshold, so never zero
    a_edge_strength: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_edge_res |-> m_strength != '0)
        else $error("edge flagged with zero strength");

    // top row and left column are borders
    a_border_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_row_index == '0 || m_col_index == '0) |-> m_strength == '0)
        else $error("border pixel with nonzero strength");

    // last result of a frame is never on row 0 or column 0
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> m_row_index != '0 && m_col_index != '0)
        else $error("frame end at an impossible position");

endmodule

bind zero_crossing_edge_detector_unit zcd_checker u_zcd_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for zero_crossing_edge_detector_unit.
// Needs only zcd_pkg and the block's RTL; an in-bench predictor tracks the line
// buffers and counters and checks every result item field by field.
module testbench;
    import zcd_pkg::*;

    localparam int SW             = SAMPLE_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles before giving up
    localparam int HOLD_CYCLES    = 200;    // long receiver hold-off
    localparam int DRAIN_CYCLES   = 6;      // idle wait after the last expected result

    // Address 3 decodes to nothing; a write there must leave all registers alone.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE = 2'd3;

    localparam logic signed [SW-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SW-1:0] SAMPLE_MAX = 16'sh7FFF;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic [STR_BITS-1:0] strength;
        logic                is_edge;
        logic                last;
    } zc_pixel_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports (all inputs known from time zero)
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    logic          s_valid  = 1'b0;
    logic          s_ready;
    logic [SW-1:0] s_sample = '0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [ROW_BITS-1:0] m_row_index;
    logic [COL_BITS-1:0] m_col_index;
    logic [STR_BITS-1:0] m_strength;
    logic                m_edge_res;
    logic                m_frame_last;

    always #5 aclk = ~aclk;

    zero_crossing_edge_detector_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_index  (m_row_index),
        .m_col_index  (m_col_index),
        .m_strength   (m_strength),
        .m_edge_res   (m_edge_res),
        .m_frame_last (m_frame_last)
    );

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the registers, line buffers and
    // counters. Buffers start at zero; unwritten entries never reach a result.
    // ------------------------------------------------------------------
    int cfg_width  = WIDTH_RST;
    int cfg_height = HEIGHT_RST;
    int cfg_thresh = 0;

    logic signed [SW-1:0] old_row [MAX_WIDTH_DEF] = '{default: '0};
    logic signed [SW-1:0] mid_row [MAX_WIDTH_DEF] = '{default: '0};
    logic signed [SW-1:0] left_px = '0;
    int row_pos = 0;
    int col_pos = 0;

    zc_pixel_t expected_pixels [$];
    zc_pixel_t want;

    int fail_count   = 0;
    int samples_sent = 0;
    int quiet_cycles = 0;

    // traffic shaping, set by the tests
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    logic hold_request = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_count   = 0;

    function automatic int clamp_dim(input int v, input int hi);
        if (v < GEOM_MIN) return GEOM_MIN;
        if (v > hi) return hi;
        return v;
    endfunction

    // Magnitude of one pixel pair; a zero pixel borrows its neighbor first.
    function automatic int crossing(input int a, input int alt, input int b);
        if (a == 0) a = alt;
        if ((a < 0 && b > 0) || (a > 0 && b < 0))
            return (a < 0 ? -a : a) + (b < 0 ? -b : b);
        return 0;
    endfunction

    // Advance the predictor by one accepted item; queue the result it causes.
    function automatic void predict_pixel(input logic signed [SW-1:0] below);
        int w, h, r, c, rr, here, above, right, sum;
        zc_pixel_t px;
        w     = clamp_dim(cfg_width, MAX_WIDTH_DEF);
        h     = clamp_dim(cfg_height, HEIGHT_MAX);
        r     = row_pos;
        c     = col_pos;
        here  = mid_row[c];
        above = old_row[c];
        if (r >= 1) begin
            rr  = r - 1;
            sum = 0;
            // borders report zero strength
            if (rr >= 1 && rr + 2 <= h && c >= 1 && c + 2 <= w) begin
                right = mid_row[c + 1];
                sum   = crossing(here, left_px, right) + crossing(here, above, below);
            end
            px.row      = rr[ROW_BITS-1:0];
            px.col      = c[COL_BITS-1:0];
            px.strength = sum[STR_BITS-1:0];
            px.is_edge  = (sum > cfg_thresh);
            px.last     = (rr + 2 == h) && (c + 1 == w);
            expected_pixels.push_back(px);
        end
        old_row[c] = here;
        mid_row[c] = below;
        left_px    = here;
        // counters at or past a shrunken limit wrap right here
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : (r + 1) % (1 << ROW_BITS);
        end else begin
            col_pos = c + 1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("result with nothing expected: row %0d col %0d",
                       m_row_index, m_col_index);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_row_index !== want.row) begin
                    $error("row_index: expected %0d, actual %0d", want.row, m_row_index);
                    fail_count++;
                end
                if (m_col_index !== want.col) begin
                    $error("col_index: expected %0d, actual %0d", want.col, m_col_index);
                    fail_count++;
                end
                if (m_strength !== want.strength) begin
                    $error("strength: expected %0d, actual %0d", want.strength, m_strength);
                    fail_count++;
                end
                if (m_edge_res !== want.is_edge) begin
                    $error("edge_res: expected %0d, actual %0d", want.is_edge, m_edge_res);
                    fail_count++;
                end
                if (m_frame_last !== want.last) begin
                    $error("frame_last: expected %0d, actual %0d", want.last, m_frame_last);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, or one long hold-off on request so the
    // block fills up and drops s_ready.
    always @(posedge aclk) begin
        if (hold_request && !hold_done) begin
            m_ready <= 1'b0;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
            if (!hold_request) begin
                hold_done  <= 1'b0;
                hold_count <= 0;
            end
        end
    end

    // Watchdog: too long without any handshake means the block hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // One sample item; optional idle gap first, then hold until accepted.
    task automatic push_sample(input logic signed [SW-1:0] v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pixel(v);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:     cfg_width  = val[GEOM_BITS-1:0];
            CFG_HEIGHT:    cfg_height = val[GEOM_BITS-1:0];
            CFG_THRESHOLD: cfg_thresh = val[STR_BITS-1:0];
            default:       ;
        endcase
        @(posedge aclk);
    endtask

    // Geometry write with junk in the unused upper data bits.
    task automatic write_geom(input logic [CFG_ADDR_BITS-1:0] idx, input int dim);
        logic [CFG_DATA_BITS-1:0] val;
        val = $urandom();
        val[GEOM_BITS-1:0] = dim[GEOM_BITS-1:0];
        write_reg(idx, val);
    endtask

    // Stop sending, wait for every result, then let row-0 items drain too.
    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Random items until the predictor sits at the given position.
    task automatic send_until(input int r, input int c);
        do
            push_sample(pick_sample());
        while (!(row_pos == r && col_pos == c));
    endtask

    // Heavy on zeros, extremes and small mixed-sign values so that
    // crossings and neighbor substitution happen often.
    function automatic logic signed [SW-1:0] pick_sample();
        int v;
        case ($urandom_range(9))
            0, 1, 2: return '0;
            3: begin
                case ($urandom_range(3))
                    0:       return SAMPLE_MIN;
                    1:       return SAMPLE_MAX;
                    2:       return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            4, 5, 6: begin
                v = $urandom_range(30);
                return v - 15;
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_threshold();
        case ($urandom_range(3))
            0:       return '0;
            1:       return STRENGTH_MAX;
            2:       return $urandom_range(200);
            default: return $urandom_range(131071);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // 4x4 frame at the reset threshold of zero: row 0 gives nothing, the
    // last row is never described, borders read zero, zero pixels borrow
    // the left and upper neighbor, and one pixel reaches full strength.
    task automatic test_directed_frame();
        logic signed [SW-1:0] frame_px [16] = '{
            16'sd5,     16'sd3,     16'sd0,     16'sd7,
            SAMPLE_MIN, 16'sd0,     SAMPLE_MAX, 16'sd9,
            SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 16'sd0,
            16'sd0,     SAMPLE_MAX, SAMPLE_MIN, 16'sd1
        };
        write_reg(CFG_WIDTH, 17'd4);
        write_reg(CFG_HEIGHT, 17'd4);
        foreach (frame_px[i]) push_sample(frame_px[i]);
        quiesce();
    endtask

    // Width 0 and height 2 clamp to 3x3; the full-strength center must not
    // mark an edge when the threshold equals it. The spare address is dead.
    task automatic test_clamped_geometry();
        logic signed [SW-1:0] frame_px [9] = '{
            16'sd1, 16'sd7,     16'sd1,
            16'sd4, SAMPLE_MIN, SAMPLE_MAX,
            -16'sd5, SAMPLE_MAX, -16'sd1
        };
        write_reg(CFG_WIDTH, 17'd0);
        write_reg(CFG_HEIGHT, 17'd2);
        write_reg(CFG_THRESHOLD, 17'd131070);
        write_reg(CFG_SPARE, 17'h1FFFF);
        foreach (frame_px[i]) push_sample(frame_px[i]);
        quiesce();
    endtask

    // Small random geometries under each idling mix.
    task automatic test_random_frames();
        int src_mix  [4] = '{0, 58, 0, 35};
        int sink_mix [4] = '{0, 0, 58, 35};
        int mark;
        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = src_mix[p];
            sink_stall_pct = sink_mix[p];
            repeat (3) begin
                write_geom(CFG_WIDTH, $urandom_range(16));
                write_geom(CFG_HEIGHT, $urandom_range(8));
                write_reg(CFG_THRESHOLD, pick_threshold());
                mark = samples_sent;
                while (samples_sent - mark < 85) send_until(0, 0);
                quiesce();
            end
        end
    endtask

    // Shrink width, then height, mid-frame; the column counter past the new width
    // must wrap on the next item, the row counter past the new height at row end.
    task automatic test_mid_frame_resize();
        src_idle_pct   = 35;
        sink_stall_pct = 35;
        write_geom(CFG_WIDTH, 9);
        write_geom(CFG_HEIGHT, 8);
        write_reg(CFG_THRESHOLD, pick_threshold());
        send_until(3, 7);
        quiesce();
        write_geom(CFG_WIDTH, 5);
        send_until(5, 2);
        quiesce();
        write_geom(CFG_HEIGHT, 3);
        send_until(0, 0);
        send_until(0, 0);
        quiesce();
    endtask

    // Long receiver hold-off while items keep coming, then a sender pause
    // mid-frame until every result is back.
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_geom(CFG_WIDTH, 6);
        write_geom(CFG_HEIGHT, 5);
        write_reg(CFG_THRESHOLD, pick_threshold());
        send_until(1, 0);
        hold_request <= 1'b1;
        repeat (40) push_sample(pick_sample());
        hold_request <= 1'b0;
        quiesce();
        src_idle_pct   = 35;
        sink_stall_pct = 35;
        send_until(0, 0);
        quiesce();
    endtask

    // Width 2047 clamps to 1024: two full rows reach column 1023, then the
    // width shrinks to finish the frame quickly.
    task automatic test_widest_rows();
        src_idle_pct   = 35;
        sink_stall_pct = 35;
        write_reg(CFG_WIDTH, 17'h007FF);
        write_geom(CFG_HEIGHT, 3);
        write_reg(CFG_THRESHOLD, pick_threshold());
        send_until(2, 0);
        quiesce();
        write_geom(CFG_WIDTH, 4);
        send_until(0, 0);
        quiesce();
    endtask

    // Height 1500 clamps to 1024: one narrow frame down to row 1022.
    task automatic test_tallest_frame();
        src_idle_pct   = 0;
        sink_stall_pct = 58;
        write_reg(CFG_WIDTH, 17'h1F803);
        write_reg(CFG_HEIGHT, 17'd1500);
        write_reg(CFG_THRESHOLD, pick_threshold());
        send_until(0, 0);
        quiesce();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_frame();
        test_clamped_geometry();
        test_random_frames();
        test_mid_frame_resize();
        test_backpressure();
        test_widest_rows();
        test_tallest_frame();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
